// ----- rtl/fadd_pkg.sv -----
// ----------------------------------------------------------------------------
// fadd_pkg
// Shared constants and types for the single-precision adder.
// ----------------------------------------------------------------------------
`default_nettype none
package fadd_pkg;
  localparam int unsigned WordWidth = 32;
  localparam logic [31:0] NanBits   = 32'hfff00000;
  localparam logic [31:0] MagMask   = 32'h7fffffff;
  localparam logic [31:0] InfBits   = 32'h7f800000;
  localparam logic [7:0]  ExpMax    = 8'hff;
  localparam logic [7:0]  FarShift  = 8'd26;

  typedef logic [31:0] word_t;
endpackage
`default_nettype wire

// ----- rtl/fadd_stream_if.sv -----
// ----------------------------------------------------------------------------
// fadd_stream_if
// Valid/ready channel carrying a payload of configurable width.
// ----------------------------------------------------------------------------
`default_nettype none
interface fadd_stream_if #(
  parameter int unsigned Width = 32
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/fadd_pair_if.sv -----
// ----------------------------------------------------------------------------
// fadd_pair_if
// Valid/ready channel carrying the two addends.
// ----------------------------------------------------------------------------
`default_nettype none
interface fadd_pair_if;
  logic        valid;
  logic        ready;
  logic [31:0] operand_a;
  logic [31:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface
`default_nettype wire

// ----- rtl/float32_adder_ftz.sv -----
// ----------------------------------------------------------------------------
// float32_adder_ftz
// Single-precision adder with flush-to-zero inputs and a fixed NaN pattern.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload
//   -------  ---------  --------------------------------
//   in       sink       operand_a[31:0], operand_b[31:0]
//   out      source     data[31:0] (the sum bit pattern)
//
// An accepted pair is registered in the input register, passes through the
// single add/normalise/round path and is captured in the result register,
// from which the sum leaves; one transfer per cycle is sustained while the
// output is not stalled.
// Reset clears both valid flags. A stalled output holds its result while the
// input stage keeps advancing whenever the result register is free or
// being emptied in the same cycle.
`default_nettype none
module float32_adder_ftz
  import fadd_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  fadd_pair_if.sink  in,
  fadd_stream_if.source out
);
  logic  in_valid;
  word_t in_a, in_b;
  word_t sum_comb;
  logic  out_valid;
  word_t out_data;
  logic  adv;

  // The result register accepts whenever it is empty or being drained.
  assign adv      = ~out_valid | out.ready;
  assign in.ready = ~in_valid | adv;

  fadd_core u_core (.a(in_a), .b(in_b), .sum(sum_comb));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in.ready) begin
        in_valid <= in.valid;
      end
      if (adv) begin
        out_valid <= in_valid;
      end
    end
    if (in.ready && in.valid) begin
      in_a <= in.operand_a;
      in_b <= in.operand_b;
    end
    if (adv && in_valid) begin
      out_data <= sum_comb;
    end
  end

  assign out.valid = out_valid;
  assign out.data  = out_data;
endmodule
`default_nettype wire

// ----- rtl/fadd_lzc.sv -----
// ----------------------------------------------------------------------------
// fadd_lzc
// Leading-zero count of a 27-bit value, 27 for zero, as a priority tree.
// ----------------------------------------------------------------------------
`default_nettype none
module fadd_lzc (
  input  wire logic [26:0] value,
  output logic      [4:0]  count
);
  logic [31:0] padded;
  logic [15:0] l16;
  logic [7:0]  l8;
  logic [3:0]  l4;
  logic [1:0]  l2;
  logic        z16, z8, z4, z2, z1;

  always_comb begin
    padded = {value, 5'b11111};
    z16 = (padded[31:16] == 16'd0);
    l16 = z16 ? padded[15:0] : padded[31:16];
    z8  = (l16[15:8] == 8'd0);
    l8  = z8 ? l16[7:0] : l16[15:8];
    z4  = (l8[7:4] == 4'd0);
    l4  = z4 ? l8[3:0] : l8[7:4];
    z2  = (l4[3:2] == 2'd0);
    l2  = z2 ? l4[1:0] : l4[3:2];
    z1  = ~l2[1];
    count = {z16, z8, z4, z2, z1};
    if (value == 27'd0) begin
      count = 5'd27;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/fadd_core.sv -----
// ----------------------------------------------------------------------------
// fadd_core
// Combinational add path: special cases, alignment, add/subtract, normalise,
// round to nearest even.
// ----------------------------------------------------------------------------
`default_nettype none
module fadd_core
  import fadd_pkg::*;
(
  input  wire word_t a,
  input  wire word_t b,
  output word_t      sum
);
  logic        a_nan, b_nan, a_inf, b_inf, a_big;
  word_t       op_hi, op_lo;
  logic [7:0]  el, es, d;
  logic [26:0] ml, ms, ms_sh, msk;
  logic        sticky, sl;
  logic [27:0] diff;
  logic [27:0] m;
  logic [4:0]  lz;
  logic [8:0]  e;
  logic [27:0] mr;

  // Special-case detection, operand ordering and alignment of the smaller operand to the larger exponent.
  always_comb begin
    a_nan = (a[30:23] == ExpMax) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == ExpMax) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == ExpMax) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == ExpMax) && (b[22:0] == 23'd0);
    a_big = (a & MagMask) > (b & MagMask);
    op_hi = a_big ? a : b;
    op_lo = a_big ? b : a;
    el = op_hi[30:23];
    es = op_lo[30:23];
    d  = el - es;
    ml = {1'b1, op_hi[22:0], 3'b000};
    ms = {1'b1, op_lo[22:0], 3'b000};
    ms_sh = (d >= FarShift) ? 27'd0 : (ms >> d[4:0]);
    msk = (d >= FarShift) ? '1 : ((27'd1 << d[4:0]) - 27'd1);
    sticky = (ms & msk) != 27'd0;
    sl = op_hi[31];
  end

  // The difference is formed on its own so that the leading-zero count
  // never sees the normalised value.
  assign diff = {1'b0, ml} - {1'b0, ms_sh | {26'd0, sticky}};

  fadd_lzc u_lzc (.value(diff[26:0]), .count(lz));

  always_comb begin
    e = {1'b0, el};
    if (op_lo[31] == sl) begin
      m = ({1'b0, ms_sh} + {1'b0, ml}) | {27'd0, sticky};
      if (m[27]) begin
        e = e + 9'd1;
        m = {1'b0, m[27:2], m[1] | m[0]};
      end
    end else begin
      e = e - {4'd0, lz};
      m = diff << lz;
    end
    mr = m;
    if (mr[2] && (mr[3] || mr[1] || mr[0])) begin
      mr = mr + 28'd8;
      if (mr[27]) begin
        e  = e + 9'd1;
        mr = mr >> 1;
      end
    end

    if (a_nan || b_nan) begin
      sum = NanBits;
    end else if (a_inf && b_inf) begin
      sum = (a[31] == b[31]) ? a : NanBits;
    end else if (a_inf) begin
      sum = a;
    end else if (b_inf) begin
      sum = b;
    end else if (a[30:23] == 8'd0 && b[30:23] == 8'd0) begin
      sum = {op_hi[31], 31'd0};
    end else if (a[30:23] == 8'd0) begin
      sum = b;
    end else if (b[30:23] == 8'd0) begin
      sum = a;
    end else if (d >= FarShift) begin
      sum = op_hi;
    end else if (op_lo[31] != sl && (lz == 5'd27 || {3'd0, lz} >= el)) begin
      // Exact cancellation (count 27) or underflow during normalisation.
      sum = {sl, 31'd0};
    end else if (e >= {1'b0, ExpMax}) begin
      sum = {sl, 31'd0} | InfBits;
    end else if (e == 9'd0) begin
      sum = {sl, 31'd0};
    end else begin
      sum = {sl, e[7:0], mr[25:3]};
    end
  end
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks the single-precision adder against a predictor of its own.
// Operand pairs are driven over a valid/ready channel from a queue filled by
// a directed list and then by random pairs, and every sum is compared with
// the oldest predicted sum. Both sides idle at random in the first two of
// three phases, and the receiver stalls once for a long stretch to push the
// block into back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import fadd_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fadd_pair_if   pair_ch ();
  fadd_stream_if #(.Width(WordWidth)) sum_ch ();

  float32_adder_ftz u_dut (
    .clk (clk),
    .rst (rst),
    .in  (pair_ch.sink),
    .out (sum_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A single add, written out step by step. The significand carries the
  // hidden one at bit 26 and guard, round and sticky bits below the
  // fraction; bit 27 holds a carry out of the add.
  function automatic word_t predict_sum(input word_t a, input word_t b);
    logic [7:0]  exp_a, exp_b, exp_l, exp_s, shift;
    logic [27:0] sig_l, sig_s, sig;
    logic        sticky, sign_l;
    logic [8:0]  exp_r;
    int          lz;
    word_t       big, lit;
    exp_a = a[30:23];
    exp_b = b[30:23];
    // NaN inputs, then infinities.
    if ((exp_a == ExpMax && a[22:0] != 0) || (exp_b == ExpMax && b[22:0] != 0))
      return NanBits;
    if (exp_a == ExpMax && exp_b == ExpMax)
      return (a[31] == b[31]) ? a : NanBits;
    if (exp_a == ExpMax) return a;
    if (exp_b == ExpMax) return b;
    // Subnormals are flushed; two flushed operands give a signed zero.
    if (exp_a == 0 && exp_b == 0)
      return ((a & MagMask) > (b & MagMask)) ? {a[31], 31'b0} : {b[31], 31'b0};
    if (exp_a == 0) return b;
    if (exp_b == 0) return a;
    // On equal magnitudes operand b counts as the larger.
    if ((a & MagMask) > (b & MagMask)) begin
      big = a; lit = b;
    end else begin
      big = b; lit = a;
    end
    exp_l = big[30:23];
    exp_s = lit[30:23];
    shift = exp_l - exp_s;
    if (shift >= FarShift) return big;
    sig_l = {2'b01, big[22:0], 3'b000};
    sig_s = {2'b01, lit[22:0], 3'b000};
    sticky = ((sig_s & ((28'd1 << shift) - 28'd1)) != 0);
    sig_s = sig_s >> shift;
    sign_l = big[31];
    exp_r = {1'b0, exp_l};
    if (big[31] == lit[31]) begin
      sig = (sig_l + sig_s) | sticky;
      if (sig[27]) begin
        exp_r = exp_r + 1;
        sig = (sig >> 1) | sig[0];
      end
    end else begin
      sig = sig_l - (sig_s | sticky);
      if (sig == 0) return {sign_l, 31'b0};
      lz = 0;
      while (lz < 27 && !sig[26 - lz]) lz++;
      // Normalising down to exponent zero or below underflows to zero.
      if (lz >= exp_r) return {sign_l, 31'b0};
      sig = sig << lz;
      exp_r = exp_r - lz;
    end
    // Round to nearest, ties to even.
    if (sig[2] && (sig[3] || sig[1] || sig[0])) begin
      sig = sig + 8;
      if (sig[27]) begin
        exp_r = exp_r + 1;
        sig = sig >> 1;
      end
    end
    if (exp_r >= ExpMax) return {sign_l, InfBits[30:0]};
    if (exp_r == 0) return {sign_l, 31'b0};
    return {sign_l, exp_r[7:0], sig[25:3]};
  endfunction

  word_t pending_a[$];
  word_t pending_b[$];
  word_t expected_sums[$];

  int  send_idle_pct = 29;
  int  recv_idle_pct = 76;
  int  hold_off      = 0;
  bit  failed        = 1'b0;
  longint cycles     = 0;

  // Driver: a transfer completes at the edge where valid and ready are both
  // high, so the next pair (or an idle cycle) is set up at that same edge.
  always @(posedge clk) begin
    if (rst) begin
      pair_ch.valid     <= 1'b0;
      pair_ch.operand_a <= '0;
      pair_ch.operand_b <= '0;
    end else if (!pair_ch.valid || pair_ch.ready) begin
      if (pending_a.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        pair_ch.valid     <= 1'b1;
        pair_ch.operand_a <= pending_a[0];
        pair_ch.operand_b <= pending_b[0];
        expected_sums.push_back(predict_sum(pending_a[0], pending_b[0]));
        void'(pending_a.pop_front());
        void'(pending_b.pop_front());
      end else begin
        pair_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver ready, with the long hold-off counted down here.
  always @(posedge clk) begin
    if (rst) begin
      sum_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off     <= hold_off - 1;
      sum_ch.ready <= 1'b0;
    end else begin
      sum_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each sum transfer with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && sum_ch.valid && sum_ch.ready) begin
      if (expected_sums.size() == 0) begin
        $error("sum_bits: unexpected transfer, actual %h", sum_ch.data);
        failed = 1'b1;
      end else begin
        if (sum_ch.data !== expected_sums[0]) begin
          $error("sum_bits: expected %h actual %h", expected_sums[0], sum_ch.data);
          failed = 1'b1;
        end
        void'(expected_sums.pop_front());
      end
    end
  end

  // Watchdog, far above the slowest legal run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("float32_adder_ftz: mismatch");
      $finish;
    end
  end

  function automatic word_t rand_operand();
    word_t w;
    w = $urandom;
    case ($urandom_range(9))
      0: w[30:23] = 8'h00;
      1: w[30:23] = 8'hff;
      2: w[30:23] = 8'hfe;
      3: w[30:23] = 8'h01;
      default: ;
    endcase
    return w;
  endfunction

  task automatic queue_pair(input word_t a, input word_t b);
    pending_a.push_back(a);
    pending_b.push_back(b);
  endtask

  task automatic queue_random(input int count);
    word_t a, b;
    for (int i = 0; i < count; i++) begin
      a = rand_operand();
      b = rand_operand();
      // Mostly keep the exponents close so that alignment, cancellation and
      // rounding get exercised rather than the far-apart shortcut.
      if ($urandom_range(3) != 0) b[30:23] = a[30:23] + $urandom_range(6) - 3;
      if ($urandom_range(7) == 0) b = {~a[31], a[30:0]} ^ $urandom_range(3);
      queue_pair(a, b);
    end
  endtask

  task automatic drain();
    wait (pending_a.size() == 0 && expected_sums.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    // Directed pairs: NaNs, infinities, flushed subnormals and zeros, far
    // apart operands, exact cancellation, underflow, overflow and ties.
    queue_pair(32'h7fc00000, 32'h3f800000);
    queue_pair(32'h3f800000, 32'hff800001);
    queue_pair(32'h7f800000, 32'h7f800000);
    queue_pair(32'h7f800000, 32'hff800000);
    queue_pair(32'hff800000, 32'h3f800000);
    queue_pair(32'h3f800000, 32'h7f800000);
    queue_pair(32'h00000001, 32'h80000002);
    queue_pair(32'h80000000, 32'h00000000);
    queue_pair(32'h807fffff, 32'h40490fdb);
    queue_pair(32'hc0000000, 32'h00400000);
    queue_pair(32'h4b800000, 32'h33800000);
    queue_pair(32'h33800000, 32'h4b800000);
    queue_pair(32'h3f800000, 32'hbf800000);
    queue_pair(32'hbf800000, 32'h3f800000);
    queue_pair(32'h00800000, 32'h80800001);
    queue_pair(32'h00800001, 32'h80800000);
    queue_pair(32'h7f7fffff, 32'h7f7fffff);
    queue_pair(32'hff7fffff, 32'hff000000);
    queue_pair(32'h3f800000, 32'h33800000);
    queue_pair(32'h3f800001, 32'h33800000);
    queue_pair(32'h3f800000, 32'hb3800000);
    queue_pair(32'h3fffffff, 32'h3fffffff);
    queue_pair(32'hffffffff, 32'h00000000);
    queue_pair(32'h3f800000, 32'hbf7fffff);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    queue_random(600);
    drain();

    send_idle_pct = 76;
    recv_idle_pct = 29;
    queue_random(600);
    drain();

    // No idling; the receiver holds off once while the sender keeps offering.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(600);
    @(posedge clk);
    hold_off <= 300;
    drain();

    if (!failed) begin
      $display("float32_adder_ftz: match");
    end else begin
      $display("float32_adder_ftz: mismatch");
    end
    $finish;
  end
endmodule
